/* sv/twr_pkg.sv */
// ----------------------------------------------------------------------------
// twr_pkg
// Shared types and constants of the moving-window tachometer.
// ----------------------------------------------------------------------------
package twr_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_REV = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TIME_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_RPM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_OUT = 3'd4;

    localparam int WLEN_W = 7;
    localparam int PPR_W = 10;
    localparam int MS_W = 14;
    localparam int THR_W = 16;

    localparam logic [WLEN_W-1:0] WLEN_RST = 7'd10;
    localparam logic [PPR_W-1:0] PPR_RST = 10'd1;
    localparam logic [MS_W-1:0] MS_RST = 14'd1000;

    localparam int CNT_W = 32;
    localparam int DIFF_W = 16;
    localparam int Q_W = 16;
    localparam int QCNT_W = 4;
    localparam int DEN_W = MS_W + PPR_W;

    localparam logic [Q_W-1:0] RPM_SCALE = 16'd60000;
    localparam logic [Q_W-1:0] RPM_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_START,
        S_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } t_div_res;

endpackage

/* sv/twr_ram.sv */
// ----------------------------------------------------------------------------
// twr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/twr_div.sv */
// ----------------------------------------------------------------------------
// twr_div
// Saturating restoring divider: 16-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module twr_div #(
    parameter int NUM_W = 39
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [NUM_W-1:0]         i_num,
    input  logic [twr_pkg::DEN_W-1:0] i_den,
    output twr_pkg::t_div_res        o_res
);

    localparam int DEN_W = twr_pkg::DEN_W;
    localparam int Q_W = twr_pkg::Q_W;
    localparam int CMP_W = NUM_W + DEN_W;

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [twr_pkg::QCNT_W-1:0]    r_cnt, n_cnt;
    logic [DEN_W-1:0]              r_rem, n_rem;
    logic [DEN_W-1:0]              r_den, n_den;
    logic [Q_W-1:0]                r_low, n_low;
    logic [Q_W-1:0]                r_q, n_q;
    logic [DEN_W:0]                trial;
    logic [DEN_W:0]                diff;
    logic                          ge;
    logic                          sat;

    always_comb begin
        trial = {r_rem, r_low[Q_W-1]};
        diff = trial - {1'b0, r_den};
        ge = trial >= {1'b0, r_den};
        sat = CMP_W'(i_num) >= (CMP_W'(i_den) << Q_W);

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_den = r_den;
        n_low = r_low;
        n_q = r_q;

        if (i_start) begin
            n_den = i_den;
            n_cnt = '0;
            if (sat) begin
                n_q = twr_pkg::RPM_MAX;
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_rem = DEN_W'(i_num >> Q_W);
                n_low = i_num[Q_W-1:0];
                n_q = '0;
            end
        end else if (r_busy) begin
            n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_q = {r_q[Q_W-2:0], ge};
            n_low = {r_low[Q_W-2:0], 1'b0};
            n_cnt = r_cnt + twr_pkg::QCNT_W'(1);
            if (r_cnt == '1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_low <= n_low;
        r_q <= n_q;
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_q;

endmodule

/* sv/tachometer_window_rpm_core.sv */
// ----------------------------------------------------------------------------
// tachometer_window_rpm_core
// Moving-window tachometer: ring of pulse deltas, running window sum,
// rpm = sum*60000/(window_time_ms*pulses_per_rev) saturated, rpm or
// threshold-state reporting on change.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  s       | in        | i_s_tvalid / o_s_tready    | counter_value [31:0]
//  m       | out       | o_m_tvalid / i_m_tready    | report_value  [15:0]
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | index [2:0], data [15:0]
//
//  Each tick passes these steps from acceptance until its result is registered:
//  ring read/modify/write, a multiply state, a divider start state, then the 16-step divider loop.
//  A tick that saturates skips the divider loop.
//  Reset clears state and control registers; the ring RAM is not cleared and is tracked by the fill count.
//  A pending result does not block acceptance; a new result waits while an older one is pending without i_m_tready.
// ----------------------------------------------------------------------------
module tachometer_window_rpm_core #(
    parameter int RING_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [31:0]                     i_s_tdata,   // [31:0] counter_value
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [15:0]                     o_m_tdata,   // [15:0] report_value
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [twr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [twr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int LEN_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = twr_pkg::DIFF_W + LEN_W;
    localparam int NUM_W = SUM_W + twr_pkg::Q_W;
    localparam int DEN_W = twr_pkg::DEN_W;

    twr_pkg::t_state                 r_state, n_state;
    logic [twr_pkg::WLEN_W-1:0]      r_wlen, n_wlen;
    logic [twr_pkg::PPR_W-1:0]       r_ppr, n_ppr;
    logic [twr_pkg::MS_W-1:0]        r_ms, n_ms;
    logic [twr_pkg::THR_W-1:0]       r_thr, n_thr;
    logic                            r_inv, n_inv;
    logic [ADDR_W-1:0]               r_head, n_head;
    logic [LEN_W-1:0]                r_fill, n_fill;
    logic [twr_pkg::CNT_W-1:0]       r_last, n_last;
    logic [SUM_W-1:0]                r_sum, n_sum;
    logic [twr_pkg::Q_W-1:0]         r_rpm_prev, n_rpm_prev;
    logic                            r_bin_prev, n_bin_prev;
    logic                            r_m_valid, n_m_valid;
    logic [twr_pkg::Q_W-1:0]         r_m_data, n_m_data;
    logic [twr_pkg::DIFF_W-1:0]      r_diff, n_diff;
    logic [NUM_W-1:0]                r_num, n_num;
    logic [DEN_W-1:0]                r_den, n_den;

    logic [LEN_W-1:0]                eff_len;
    logic [twr_pkg::MS_W-1:0]        ms_eff;
    logic [twr_pkg::PPR_W-1:0]       ppr_eff;
    logic [twr_pkg::DIFF_W-1:0]      old_val;
    logic [twr_pkg::DIFF_W-1:0]      ram_rdata;
    logic [LEN_W-1:0]                head_inc;
    logic                            s_acc;
    logic                            ram_we;
    logic                            div_start;
    logic                            bin;
    logic                            emit;
    logic                            out_free;
    twr_pkg::t_div_res               div_res;

    twr_ram #(
        .WIDTH (twr_pkg::DIFF_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_head),
        .i_wdata (r_diff),
        .i_re    (s_acc),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    twr_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_res   (div_res)
    );

    assign o_s_tready = (r_state == twr_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata = r_m_data;
    assign s_acc = i_s_tvalid && o_s_tready;
    assign ram_we = (r_state == twr_pkg::S_READ);
    assign div_start = (r_state == twr_pkg::S_START);

    always_comb begin
        priority if (r_wlen == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(r_wlen) > 32'(RING_DEPTH)) begin
            eff_len = LEN_W'(RING_DEPTH);
        end else begin
            eff_len = LEN_W'(r_wlen);
        end
        ms_eff = (r_ms == '0) ? twr_pkg::MS_W'(1) : r_ms;
        ppr_eff = (r_ppr == '0) ? twr_pkg::PPR_W'(1) : r_ppr;
        old_val = (r_fill == eff_len) ? ram_rdata : '0;
        head_inc = LEN_W'(r_head) + LEN_W'(1);
        bin = (div_res.quot >= r_thr) ^ r_inv;
        emit = (div_res.quot != r_rpm_prev)
            && ((r_thr == '0) || (bin != r_bin_prev));
        out_free = !r_m_valid || i_m_tready;
    end

    always_comb begin
        n_state = r_state;
        n_wlen = r_wlen;
        n_ppr = r_ppr;
        n_ms = r_ms;
        n_thr = r_thr;
        n_inv = r_inv;
        n_head = r_head;
        n_fill = r_fill;
        n_last = r_last;
        n_sum = r_sum;
        n_rpm_prev = r_rpm_prev;
        n_bin_prev = r_bin_prev;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_data = r_m_data;
        n_diff = r_diff;
        n_num = r_num;
        n_den = r_den;

        unique case (r_state)
            twr_pkg::S_IDLE: begin
                if (s_acc) begin
                    n_diff = twr_pkg::DIFF_W'(i_s_tdata - r_last);
                    n_last = i_s_tdata;
                    n_state = twr_pkg::S_READ;
                end
            end
            twr_pkg::S_READ: begin
                n_sum = r_sum - SUM_W'(old_val) + SUM_W'(r_diff);
                n_head = (head_inc == eff_len) ? '0 : head_inc[ADDR_W-1:0];
                if (r_fill < eff_len) begin
                    n_fill = r_fill + LEN_W'(1);
                end
                n_state = twr_pkg::S_MUL;
            end
            twr_pkg::S_MUL: begin
                n_num = NUM_W'(r_sum) * NUM_W'(twr_pkg::RPM_SCALE);
                n_den = DEN_W'(ms_eff) * DEN_W'(ppr_eff);
                n_state = twr_pkg::S_START;
            end
            twr_pkg::S_START: begin
                n_state = twr_pkg::S_WAIT;
            end
            twr_pkg::S_WAIT: begin
                if (div_res.done) begin
                    n_state = twr_pkg::S_DONE;
                end
            end
            twr_pkg::S_DONE: begin
                if (!emit) begin
                    n_rpm_prev = div_res.quot;
                    n_state = twr_pkg::S_IDLE;
                end else if (out_free) begin
                    n_rpm_prev = div_res.quot;
                    n_m_valid = 1'b1;
                    if (r_thr == '0) begin
                        n_m_data = div_res.quot;
                    end else begin
                        n_bin_prev = bin;
                        n_m_data = twr_pkg::Q_W'(bin);
                    end
                    n_state = twr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = twr_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                twr_pkg::CFG_WINDOW_LEN: begin
                    n_wlen = i_cfg_data[twr_pkg::WLEN_W-1:0];
                    n_head = '0;
                    n_fill = '0;
                    n_sum = '0;
                end
                twr_pkg::CFG_PULSES_PER_REV: n_ppr = i_cfg_data[twr_pkg::PPR_W-1:0];
                twr_pkg::CFG_WINDOW_TIME_MS: n_ms = i_cfg_data[twr_pkg::MS_W-1:0];
                twr_pkg::CFG_THRESHOLD_RPM: n_thr = i_cfg_data[twr_pkg::THR_W-1:0];
                twr_pkg::CFG_INVERT_OUT: n_inv = i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= twr_pkg::S_IDLE;
            r_wlen <= twr_pkg::WLEN_RST;
            r_ppr <= twr_pkg::PPR_RST;
            r_ms <= twr_pkg::MS_RST;
            r_thr <= '0;
            r_inv <= 1'b0;
            r_head <= '0;
            r_fill <= '0;
            r_last <= '0;
            r_sum <= '0;
            r_rpm_prev <= '0;
            r_bin_prev <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wlen <= n_wlen;
            r_ppr <= n_ppr;
            r_ms <= n_ms;
            r_thr <= n_thr;
            r_inv <= n_inv;
            r_head <= n_head;
            r_fill <= n_fill;
            r_last <= n_last;
            r_sum <= n_sum;
            r_rpm_prev <= n_rpm_prev;
            r_bin_prev <= n_bin_prev;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        r_diff <= n_diff;
        r_num <= n_num;
        r_den <= n_den;
    end

endmodule
